>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	localparam int SPQ_DEPTH_DEF = 16;

	localparam int ID_W   = 16;
	localparam int PAGE_W = 16;
	localparam int PRIO_W = 8;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_INSERT  = 3'd0;
	localparam kind_t KIND_REMOVE  = 3'd1;
	localparam kind_t KIND_LOOKUP  = 3'd2;
	localparam kind_t KIND_SET_PG  = 3'd3;
	localparam kind_t KIND_SET_PR  = 3'd4;
	localparam kind_t KIND_LIST    = 3'd5;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch operands and compare vectors
		logic apply;      // single-result op: update table, load result
		logic list_emit;  // emit head of table and rotate
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // result register can take a new item
		logic empty;      // table holds no job
		logic list_last;  // current list item is the final one
	} spq_stat_t;

endpackage

>>> rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  kind_t     kind,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_LIST
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.apply     = (state_q == S_APPLY) && stat.out_free;
		cmd.list_emit = (state_q == S_LIST) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind inside {KIND_INSERT, KIND_REMOVE, KIND_LOOKUP,
								KIND_SET_PG, KIND_SET_PR}) begin
							state_q <= S_APPLY;
						end else if (kind == KIND_LIST) begin
							state_q <= S_LIST;
						end
					end
				end
				S_APPLY: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (stat.out_free && (stat.empty || stat.list_last)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/spq_table.sv
`timescale 1ns / 1ps

module spq_table
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = SPQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_cmd_t          cmd,
	output spq_stat_t         stat,
	input  kind_t             kind,
	input  logic [ID_W-1:0]   doc_id,
	input  logic [PAGE_W-1:0] page_count,
	input  logic [PRIO_W-1:0] prio,
	output logic              out_valid,
	input  logic              out_ready,
	output status_t           status,
	output logic [ID_W-1:0]   out_id,
	output logic [PAGE_W-1:0] out_pages,
	output logic [PRIO_W-1:0] out_prio,
	output logic              last
);

	localparam int N  = QUEUE_DEPTH;
	localparam int FW = $clog2(N + 1);

	// job cells, slot 0 is the head
	logic [ID_W-1:0]   id_q [N];
	logic [PAGE_W-1:0] pg_q [N];
	logic [PRIO_W-1:0] pr_q [N];
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     lcnt_q;

	// latched operation
	kind_t             op_q;
	logic [ID_W-1:0]   key_q;
	logic [PAGE_W-1:0] pgin_q;
	logic [PRIO_W-1:0] prin_q;
	logic [N-1:0]      hit_q;   // occupied and id matches
	logic [N-1:0]      ge_q;    // occupied and prio >= new prio

	logic [N-1:0]      occ;
	logic [N-1:0]      aft;     // at or behind first id match
	logic [N-1:0]      ins_aft; // at or behind the insert point
	logic [N-1:0]      first;
	logic              found;
	logic              full;
	logic              empty;
	logic [FW-1:0]     fill_m1;

	logic [ID_W-1:0]   sel_id;
	logic [PAGE_W-1:0] sel_pg;
	logic [PRIO_W-1:0] sel_pr;

	logic              out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   oid_q;
	logic [PAGE_W-1:0] opg_q;
	logic [PRIO_W-1:0] opr_q;
	logic              last_q;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			occ[i] = (FW'(i) < fill_q);
		end
	end

	// prefix OR by doubling, log2(N) steps
	always_comb begin
		aft = hit_q;
		for (int s = 1; s < N; s = s * 2) begin
			aft = aft | (aft << s);
		end
	end

	// set-priority can leave the table out of order, so the insert point is
	// the first slot that is not >= the new prio, not the edge of a run
	always_comb begin
		ins_aft = ~ge_q;
		for (int s = 1; s < N; s = s * 2) begin
			ins_aft = ins_aft | (ins_aft << s);
		end
	end

	assign first   = aft & ~(aft << 1);
	assign found   = |hit_q;
	assign full    = (fill_q == FW'(N));
	assign empty   = (fill_q == '0);
	assign fill_m1 = fill_q - FW'(1);

	always_comb begin
		sel_id = '0;
		sel_pg = '0;
		sel_pr = '0;
		for (int i = 0; i < N; i++) begin
			sel_id = sel_id | (first[i] ? id_q[i] : '0);
			sel_pg = sel_pg | (first[i] ? pg_q[i] : '0);
			sel_pr = sel_pr | (first[i] ? pr_q[i] : '0);
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.empty     = empty;
	assign stat.list_last = (lcnt_q == fill_m1);

	// operand capture and compare
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= kind;
			key_q  <= doc_id;
			pgin_q <= page_count;
			prin_q <= prio;
			for (int i = 0; i < N; i++) begin
				hit_q[i] <= occ[i] && (id_q[i] == doc_id);
				ge_q[i]  <= occ[i] && (pr_q[i] >= prio);
			end
		end
	end

	// per-cell update
	for (genvar g = 0; g < N; g++) begin : g_cell
		logic ins_here;
		logic ins_shift;
		logic rm_shift;
		logic rot_wrap;
		logic rot_next;

		if (g == 0) begin : g_head
			assign ins_here  = ins_aft[g];
			assign ins_shift = 1'b0;
		end else begin : g_body
			assign ins_here  = ins_aft[g] && !ins_aft[g-1];
			assign ins_shift = ins_aft[g-1];
		end

		if (g == N - 1) begin : g_tail
			assign rm_shift = 1'b0;
			assign rot_next = 1'b0;
		end else begin : g_mid
			assign rm_shift = aft[g];
			assign rot_next = (FW'(g) < fill_m1);
		end

		assign rot_wrap = (FW'(g) == fill_m1);

		always_ff @(posedge clk) begin
			if (cmd.apply) begin
				case (op_q)
					KIND_INSERT: begin
						if (!full) begin
							if (ins_here) begin
								id_q[g] <= key_q;
								pg_q[g] <= pgin_q;
								pr_q[g] <= prin_q;
							end else if (ins_shift) begin
								id_q[g] <= id_q[(g == 0) ? 0 : g - 1];
								pg_q[g] <= pg_q[(g == 0) ? 0 : g - 1];
								pr_q[g] <= pr_q[(g == 0) ? 0 : g - 1];
							end
						end
					end
					KIND_REMOVE: begin
						if (rm_shift) begin
							id_q[g] <= id_q[(g == N - 1) ? g : g + 1];
							pg_q[g] <= pg_q[(g == N - 1) ? g : g + 1];
							pr_q[g] <= pr_q[(g == N - 1) ? g : g + 1];
						end
					end
					KIND_SET_PG: begin
						if (first[g]) begin
							pg_q[g] <= pgin_q;
						end
					end
					KIND_SET_PR: begin
						if (first[g]) begin
							pr_q[g] <= prin_q;
						end
					end
					default: begin
					end
				endcase
			end else if (cmd.list_emit && !empty) begin
				// rotate the occupied part by one; head goes to the tail
				if (rot_wrap) begin
					id_q[g] <= id_q[0];
					pg_q[g] <= pg_q[0];
					pr_q[g] <= pr_q[0];
				end else if (rot_next) begin
					id_q[g] <= id_q[(g == N - 1) ? g : g + 1];
					pg_q[g] <= pg_q[(g == N - 1) ? g : g + 1];
					pr_q[g] <= pr_q[(g == N - 1) ? g : g + 1];
				end
			end
		end
	end

	// fill count, list counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			lcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply && (op_q == KIND_INSERT) && !full) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.apply && (op_q == KIND_REMOVE) && found) begin
				fill_q <= fill_m1;
			end

			if (cmd.capture) begin
				lcnt_q <= '0;
			end else if (cmd.list_emit) begin
				lcnt_q <= lcnt_q + FW'(1);
			end

			if (cmd.apply || cmd.list_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			last_q <= 1'b1;
			if (op_q == KIND_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
				oid_q    <= full ? '0 : key_q;
				opg_q    <= full ? '0 : pgin_q;
				opr_q    <= full ? '0 : prin_q;
			end else if (found) begin
				status_q <= ST_OK;
				oid_q    <= sel_id;
				opg_q    <= (op_q == KIND_SET_PG) ? pgin_q : sel_pg;
				opr_q    <= (op_q == KIND_SET_PR) ? prin_q : sel_pr;
			end else begin
				status_q <= ST_NOT_FOUND;
				oid_q    <= '0;
				opg_q    <= '0;
				opr_q    <= '0;
			end
		end else if (cmd.list_emit) begin
			if (empty) begin
				status_q <= ST_EMPTY;
				oid_q    <= '0;
				opg_q    <= '0;
				opr_q    <= '0;
				last_q   <= 1'b1;
			end else begin
				status_q <= ST_OK;
				oid_q    <= id_q[0];
				opg_q    <= pg_q[0];
				opr_q    <= pr_q[0];
				last_q   <= stat.list_last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = oid_q;
	assign out_pages = opg_q;
	assign out_prio  = opr_q;
	assign last      = last_q;

endmodule

>>> rtl/core/stable_priority_queue_by_id.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, doc_id, page_count, prio
// output    out_valid / out_ready  status, out_id, out_pages, out_prio, last
//
// An item is first captured, which runs the per-slot id and priority compares;
// the table is then updated and the result register loaded once it is free.
// List captures, then for each job emits the head slot and rotates the table
// while the result register is free; an empty table gives one ST_EMPTY result.
// Reset clears the fill count and control only; no clearing pass.
// A held result stalls the next update, but a new item is still taken while
// the previous result waits.

module stable_priority_queue_by_id
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = SPQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [ID_W-1:0]   doc_id,
	input  logic [PAGE_W-1:0] page_count,
	input  logic [PRIO_W-1:0] prio,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   out_id,
	output logic [PAGE_W-1:0] out_pages,
	output logic [PRIO_W-1:0] out_prio,
	output logic              last
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	// sequencing: accept, apply or list walk
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	// job cells, compares and result register
	spq_table #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.doc_id     (doc_id),
		.page_count (page_count),
		.prio       (prio),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_id     (out_id),
		.out_pages  (out_pages),
		.out_prio   (out_prio),
		.last       (last)
	);

endmodule
